// ----- src/lud_pkg.sv -----
// ----------------------------------------------------------------------------
// Lenient UTF-8 decoder package
// Shared types and constants for the byte-to-code-point decoder.
// ----------------------------------------------------------------------------
package lud_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POINT_W = 21;
  localparam int unsigned OWED_W  = 2;
  localparam int unsigned CONT_W  = 6;

  // Lead byte thresholds.
  localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_MIN  = 8'h80;

  // Payload masks.
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;

  // Continuation bytes still owed after each kind of lead byte.
  localparam logic [OWED_W-1:0] OWED_NONE  = 2'd0;
  localparam logic [OWED_W-1:0] OWED_LEAD2 = 2'd1;
  localparam logic [OWED_W-1:0] OWED_LEAD3 = 2'd2;
  localparam logic [OWED_W-1:0] OWED_LEAD4 = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              final_byte;
  } lud_in_t;

  typedef struct packed {
    logic [POINT_W-1:0] code_point;
    logic               has_point;
    logic               end_of_text;
  } lud_out_t;

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    logic [POINT_W-1:0] partial_point;
    logic [OWED_W-1:0]  bytes_owed;
  } lud_state_t;

  // What one decode step produces.
  typedef struct packed {
    lud_state_t state_nxt;
    logic       emit;
    lud_out_t   result;
  } lud_step_t;

endpackage

// ----- src/lud_step.sv -----
// ----------------------------------------------------------------------------
// Lenient UTF-8 decoder step
// Combinational decode of one byte against the current sequence state.
// ----------------------------------------------------------------------------
module lud_step (
  input  lud_pkg::lud_in_t    item,
  input  lud_pkg::lud_state_t state,
  output lud_pkg::lud_step_t  step
);
  import lud_pkg::*;

  logic [POINT_W-1:0] shifted;
  logic [BYTE_W-1:0]  b;
  logic               got;
  logic [POINT_W-1:0] point;
  lud_state_t         st_nxt;

  assign b       = item.text_byte;
  assign shifted = {state.partial_point[POINT_W-CONT_W-1:0], b[CONT_W-1:0]};

  always_comb begin
    got    = 1'b0;
    point  = '0;
    st_nxt = state;
    priority if (state.bytes_owed != OWED_NONE) begin
      // Continuation byte: taken without checking its top bits.
      st_nxt.bytes_owed    = state.bytes_owed - OWED_W'(1);
      st_nxt.partial_point = shifted;
      if (state.bytes_owed == OWED_LEAD2) begin
        got                  = 1'b1;
        point                = shifted;
        st_nxt.partial_point = '0;
      end
    end else if (b >= LEAD4_MIN) begin
      st_nxt.partial_point = POINT_W'(b & LEAD4_MASK);
      st_nxt.bytes_owed    = OWED_LEAD4;
    end else if (b >= LEAD3_MIN) begin
      st_nxt.partial_point = POINT_W'(b & LEAD3_MASK);
      st_nxt.bytes_owed    = OWED_LEAD3;
    end else if (b >= LEAD2_MIN) begin
      st_nxt.partial_point = POINT_W'(b & LEAD2_MASK);
      st_nxt.bytes_owed    = OWED_LEAD2;
    end else if (b < CONT_MIN) begin
      got   = 1'b1;
      point = POINT_W'(b);
    end else begin
      // Stray continuation byte in lead position is dropped.
      got = 1'b0;
    end

    // The end of the text discards any unfinished sequence.
    if (item.final_byte) begin
      st_nxt = '0;
    end

    step.state_nxt          = st_nxt;
    step.emit               = got | item.final_byte;
    step.result.code_point  = point;
    step.result.has_point   = got;
    step.result.end_of_text = item.final_byte;
  end

endmodule

// ----- src/lenient_utf8_decoder.sv -----
// ----------------------------------------------------------------------------
// Lenient UTF-8 decoder
// Turns a byte stream into code points without validating continuations.
// ----------------------------------------------------------------------------
// The input channel takes one text byte per transfer, with final_byte set on
// the last byte of a text. The output channel gives one transfer for each
// completed code point, and one for the final byte: that transfer carries
// end_of_text, and has_point is clear when the final byte finished no point.
// Bytes that finish nothing (leads, inner continuations, stray continuation
// bytes) give no output transfer.
// An accepted byte sits in the input register, is decoded there against
// the sequence state and lands in the output register, from which its
// result is offered. The block takes one byte every cycle while the
// output is not stalled; the throughput is set by the single decode stage,
// which updates the state for each byte that it decodes.
// When the receiver stalls, the output register holds its result and the
// input register fills, after which in_stall is raised until the result
// is taken. Reset empties both registers and clears the sequence state,
// so decoding restarts at a lead position.
// ----------------------------------------------------------------------------
module lenient_utf8_decoder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lud_pkg::lud_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lud_pkg::lud_out_t out_data
);
  import lud_pkg::*;

  logic       in_valid_r;
  lud_in_t    in_data_r;
  lud_state_t state_r;
  logic       out_valid_r;
  lud_out_t   out_data_r;
  lud_step_t  step;
  logic       advance;
  logic       out_free;

  lud_step u_step (
    .item  (in_data_r),
    .state (state_r),
    .step  (step)
  );

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= step.state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && step.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step.emit) begin
      out_data_r <= step.result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An empty result only ever marks the end of a text.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_point |-> out_data.end_of_text)
    else $error("empty result without end_of_text");

  // An empty result carries a zero code point.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_point |-> out_data.code_point == '0)
    else $error("empty result with nonzero code point");

  // Consuming the final byte of a text leaves a cleared state.
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_data_r.final_byte |=> state_r == '0)
    else $error("state not cleared after final byte");

  // No partial point is held while no continuation bytes are owed.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r.bytes_owed == OWED_NONE |-> state_r.partial_point == '0)
    else $error("partial point left over at lead position");

endmodule
